FILE: hdl/odo_pkg.sv
// Shared types and constants for the mouse delta odometer.
// Holds the channel payload structs, the job record and frame constants.
// No dependencies.
package odo_pkg;

   localparam int NumPorts   = 2;
   localparam int PortIdxW   = (NumPorts > 1) ? $clog2(NumPorts) : 1;
   localparam int NumWords   = 2 * NumPorts;
   localparam int WordIdxW   = $clog2(NumWords);
   localparam int FrameLen   = 2 * NumWords + 2;
   localparam int ByteIdxW   = $clog2(FrameLen);
   localparam int QueueDepth = 2;
   localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntW      = $clog2(QueueDepth + 1);

   localparam logic       OpMotion   = 1'b0;
   localparam logic       OpCommand  = 1'b1;
   localparam logic [7:0] CmdDump    = 8'h5A;
   localparam logic [7:0] FrameStart = 8'h55;
   localparam logic [7:0] FrameEnd   = 8'hAA;

   typedef struct packed {
      logic       op;
      logic       port;
      logic       report_ok;
      logic [7:0] motion_byte0;
      logic [7:0] motion_byte1;
      logic [7:0] motion_byte2;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   typedef enum logic {
      JOB_MOVE = 1'b0,
      JOB_DUMP = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type          kind;
      logic [PortIdxW-1:0]   port;
      logic [15:0]           dx;
      logic [15:0]           dy;
   } job_type;

endpackage

FILE: hdl/odo_front.sv
// Front end of the odometer: accepts items, drops ignored ones and
// unpacks motion deltas into jobs. Depends on odo_pkg.
module odo_front (
   input  logic             req_push,
   input  odo_pkg::req_type req_data,
   output logic             req_full,
   input  logic             q_full,
   output logic             q_push,
   output odo_pkg::job_type q_job
);

   logic        port_ok;
   logic        is_move;
   logic        is_dump;
   logic [11:0] raw_dx;
   logic [11:0] raw_dy;

   always_comb begin
      port_ok = (32'(req_data.port) < odo_pkg::NumPorts);
      is_move = (req_data.op == odo_pkg::OpMotion) && req_data.report_ok && port_ok;
      is_dump = (req_data.op == odo_pkg::OpCommand) && (req_data.rx_byte == odo_pkg::CmdDump);
      raw_dx  = {req_data.motion_byte1[3:0], req_data.motion_byte0};
      raw_dy  = {req_data.motion_byte2, req_data.motion_byte1[7:4]};

      req_full    = q_full;
      q_push      = req_push && !q_full && (is_move || is_dump);
      q_job.kind  = is_dump ? odo_pkg::JOB_DUMP : odo_pkg::JOB_MOVE;
      q_job.port  = odo_pkg::PortIdxW'(req_data.port);
      q_job.dx    = {{4{raw_dx[11]}}, raw_dx};
      q_job.dy    = {{4{raw_dy[11]}}, raw_dy};
   end

endmodule

FILE: hdl/odo_queue.sv
// Short job queue between the front and back ends of the odometer.
// Depends on odo_pkg.
module odo_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  odo_pkg::job_type job_in,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output odo_pkg::job_type job_out
);

   odo_pkg::job_type             entry_ff [odo_pkg::QueueDepth];
   logic [odo_pkg::QPtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [odo_pkg::QPtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [odo_pkg::QCntW-1:0]    count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   always_comb begin
      full    = (count_ff == odo_pkg::QCntW'(odo_pkg::QueueDepth));
      empty   = (count_ff == '0);
      job_out = entry_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == odo_pkg::QPtrW'(odo_pkg::QueueDepth - 1)) ? '0
                                                                             : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == odo_pkg::QPtrW'(odo_pkg::QueueDepth - 1)) ? '0
                                                                             : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

FILE: hdl/odo_back.sv
// Back end of the odometer: per-port accumulators, dump snapshot and
// frame serializer feeding the result channel. Depends on odo_pkg.
module odo_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  odo_pkg::job_type q_job,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output odo_pkg::rsp_type rsp_data
);

   logic [15:0]                  x_ff    [odo_pkg::NumPorts];
   logic [15:0]                  x_in    [odo_pkg::NumPorts];
   logic [15:0]                  y_ff    [odo_pkg::NumPorts];
   logic [15:0]                  y_in    [odo_pkg::NumPorts];
   logic [15:0]                  snap_ff [odo_pkg::NumWords];
   logic [15:0]                  snap_in [odo_pkg::NumWords];
   logic                         busy_ff, busy_in;
   logic [odo_pkg::ByteIdxW-1:0] idx_ff, idx_in;
   logic                         byte_done;
   logic                         last_done;
   logic                         take_move;
   logic                         take_dump;
   logic [odo_pkg::ByteIdxW-1:0] data_idx;
   logic [15:0]                  word;

   always_comb begin
      byte_done = busy_ff && rsp_pop;
      last_done = byte_done && (idx_ff == odo_pkg::ByteIdxW'(odo_pkg::FrameLen - 1));
      q_pop     = !q_empty && ((q_job.kind == odo_pkg::JOB_MOVE) || !busy_ff || last_done);
      take_move = q_pop && (q_job.kind == odo_pkg::JOB_MOVE);
      take_dump = q_pop && (q_job.kind == odo_pkg::JOB_DUMP);

      for (int p = 0; p < odo_pkg::NumPorts; p++) begin
         x_in[p]          = x_ff[p];
         y_in[p]          = y_ff[p];
         snap_in[2*p]     = snap_ff[2*p];
         snap_in[2*p + 1] = snap_ff[2*p + 1];
         if (take_move && (q_job.port == odo_pkg::PortIdxW'(p))) begin
            x_in[p] = x_ff[p] + q_job.dx;
            y_in[p] = y_ff[p] + q_job.dy;
         end
         if (take_dump) begin
            snap_in[2*p]     = x_ff[p];
            snap_in[2*p + 1] = y_ff[p];
            x_in[p]          = '0;
            y_in[p]          = '0;
         end
      end

      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (take_dump) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (last_done) begin
         busy_in = 1'b0;
      end else if (byte_done) begin
         idx_in = idx_ff + 1'b1;
      end

      data_idx  = idx_ff - 1'b1;
      word      = snap_ff[data_idx[odo_pkg::WordIdxW:1]];
      rsp_empty = !busy_ff;
      rsp_data.last = (idx_ff == odo_pkg::ByteIdxW'(odo_pkg::FrameLen - 1));
      if (idx_ff == '0) begin
         rsp_data.tx_byte = odo_pkg::FrameStart;
      end else if (rsp_data.last) begin
         rsp_data.tx_byte = odo_pkg::FrameEnd;
      end else begin
         rsp_data.tx_byte = data_idx[0] ? word[15:8] : word[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         for (int p = 0; p < odo_pkg::NumPorts; p++) begin
            x_ff[p] <= '0;
            y_ff[p] <= '0;
         end
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

endmodule

FILE: hdl/mouse_delta_odometer.sv
// Top level of the mouse delta odometer.
// Instantiates odo_front, odo_queue and odo_back; uses odo_pkg.
//
//   channel   handshake            payload            direction
//   req_      req_push / req_full  odo_pkg::req_type  in
//   rsp_      rsp_pop / rsp_empty  odo_pkg::rsp_type  out
//
// One item per cycle sustained while req_full is low; a kept item reaches the
// accumulators through a combinational front decode and one queue stage.
// A dump yields FrameLen (10) transfers, one per cycle while rsp_pop is high;
// motion items keep flowing during a frame, a second dump waits for its end.
// Synchronous active-high reset clears the accumulators and the queue.
module mouse_delta_odometer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  odo_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output odo_pkg::rsp_type rsp_data
);

   logic             q_full;
   logic             q_push;
   logic             q_empty;
   logic             q_pop;
   odo_pkg::job_type front_job;
   odo_pkg::job_type back_job;

   odo_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (front_job)
   );

   odo_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .job_in  (front_job),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .job_out (back_job)
   );

   odo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (back_job),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/odo_checker.sv
// Port-level checks for the mouse delta odometer, bound to the top level.
// Depends on odo_pkg and mouse_delta_odometer.
module odo_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input odo_pkg::rsp_type rsp_data
);

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last) |-> (rsp_data.tx_byte == odo_pkg::FrameEnd))
      else $error("last byte is not the frame end marker");

   a_frame_unbroken: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=> !rsp_empty)
      else $error("frame broken off before its last byte");

   a_next_frame_start: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_data.last) |=>
         (rsp_empty || (rsp_data.tx_byte == odo_pkg::FrameStart)))
      else $error("new frame does not open with the start marker");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind mouse_delta_odometer odo_checker u_odo_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for mouse_delta_odometer: directed and random motion and dump traffic.
// Predicts each dump frame from its own copy of the accumulators and checks every transfer.
// Depends on odo_pkg and the mouse_delta_odometer RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 20;
   localparam int MaxGap      = 40;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   odo_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop  = 1'b0;
   odo_pkg::rsp_type rsp_data;

   logic [15:0]      x_sum [odo_pkg::NumPorts];
   logic [15:0]      y_sum [odo_pkg::NumPorts];
   odo_pkg::rsp_type frame_q [$];
   odo_pkg::rsp_type want;

   int error_count        = 0;
   int sent_count         = 0;
   int frame_count        = 0;
   int byte_count         = 0;
   int cycle_count        = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   mouse_delta_odometer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   function automatic logic [15:0] sext12(input logic [11:0] v);
      return {{4{v[11]}}, v};
   endfunction

   function automatic void push_frame_byte(input logic [7:0] b, input logic fin);
      odo_pkg::rsp_type r;
      r.tx_byte = b;
      r.last    = fin;
      frame_q.push_back(r);
   endfunction

   function automatic void clear_sums();
      for (int p = 0; p < odo_pkg::NumPorts; p++) begin
         x_sum[p] = '0;
         y_sum[p] = '0;
      end
   endfunction

   function automatic void accumulate_or_dump(input odo_pkg::req_type item);
      if (item.op == odo_pkg::OpMotion) begin
         if (item.report_ok && int'(item.port) < odo_pkg::NumPorts) begin
            x_sum[item.port] += sext12({item.motion_byte1[3:0], item.motion_byte0});
            y_sum[item.port] += sext12({item.motion_byte2, item.motion_byte1[7:4]});
         end
      end else if (item.rx_byte == odo_pkg::CmdDump) begin
         push_frame_byte(odo_pkg::FrameStart, 1'b0);
         for (int p = 0; p < odo_pkg::NumPorts; p++) begin
            push_frame_byte(x_sum[p][7:0], 1'b0);
            push_frame_byte(x_sum[p][15:8], 1'b0);
            push_frame_byte(y_sum[p][7:0], 1'b0);
            push_frame_byte(y_sum[p][15:8], 1'b0);
         end
         push_frame_byte(odo_pkg::FrameEnd, 1'b1);
         clear_sums();
         frame_count++;
      end
   endfunction

   function automatic odo_pkg::req_type motion_item(input logic port, input logic ok,
                                                    input logic [11:0] dx,
                                                    input logic [11:0] dy);
      odo_pkg::req_type r;
      r.op           = odo_pkg::OpMotion;
      r.port         = port;
      r.report_ok    = ok;
      r.motion_byte0 = dx[7:0];
      r.motion_byte1 = {dy[3:0], dx[11:8]};
      r.motion_byte2 = dy[11:4];
      r.rx_byte      = 8'($urandom);
      return r;
   endfunction

   function automatic odo_pkg::req_type command_item(input logic [7:0] rx);
      odo_pkg::req_type r;
      r              = odo_pkg::req_type'($urandom);
      r.op           = odo_pkg::OpCommand;
      r.motion_byte0 = 8'($urandom);
      r.motion_byte1 = 8'($urandom);
      r.motion_byte2 = 8'($urandom);
      r.rx_byte      = rx;
      return r;
   endfunction

   // entered just after a rising edge; returns at the edge of the transfer
   task automatic send_item(input odo_pkg::req_type item);
      int gap;
      gap = 0;
      while (gap < MaxGap && $urandom_range(99) < sender_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      accumulate_or_dump(item);
      sent_count++;
   endtask

   task automatic release_inputs();
      @(negedge clock);
      req_push <= 1'b0;
   endtask

   task automatic wait_drained();
      while (frame_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (frame_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transfer, expected none, got tx_byte %02h last %0b",
                     $time, rsp_data.tx_byte, rsp_data.last);
         end else begin
            want = frame_q.pop_front();
            byte_count++;
            if (rsp_data.tx_byte !== want.tx_byte) begin
               error_count++;
               $display("%0t: tx_byte expected %02h, got %02h",
                        $time, want.tx_byte, rsp_data.tx_byte);
            end
            if (rsp_data.last !== want.last) begin
               error_count++;
               $display("%0t: last expected %0b, got %0b", $time, want.last, rsp_data.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d transfers outstanding", $time, frame_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_reset_dump();
      send_item(command_item(odo_pkg::CmdDump));
   endtask

   task automatic test_delta_extremes();
      send_item(motion_item(1'b0, 1'b1, 12'h7FF, 12'h800));
      send_item(motion_item(1'b1, 1'b1, 12'h800, 12'h7FF));
      send_item(motion_item(1'b0, 1'b1, 12'hFFF, 12'hFFF));
      send_item(motion_item(1'b1, 1'b1, 12'h000, 12'h000));
      send_item(motion_item(1'b0, 1'b0, 12'h7FF, 12'h7FF));
      send_item(command_item(odo_pkg::CmdDump));
   endtask

   task automatic test_wrap();
      send_item(motion_item(1'b0, 1'b1, 12'hFFF, 12'hFFF));
      send_item(motion_item(1'b0, 1'b1, 12'h001, 12'h001));
      send_item(motion_item(1'b1, 1'b1, 12'h800, 12'h800));
      send_item(motion_item(1'b1, 1'b1, 12'h800, 12'h800));
      send_item(command_item(odo_pkg::CmdDump));
   endtask

   task automatic test_ignored_items();
      odo_pkg::req_type r;
      send_item(command_item(8'h00));
      send_item(command_item(8'hFF));
      send_item(command_item(8'h5B));
      send_item(command_item(8'hA5));
      r         = motion_item(1'b1, 1'b0, 12'h123, 12'h456);
      r.rx_byte = odo_pkg::CmdDump;
      send_item(r);
      r         = motion_item(1'b1, 1'b1, 12'h321, 12'h654);
      r.rx_byte = odo_pkg::CmdDump;
      send_item(r);
      send_item(command_item(odo_pkg::CmdDump));
   endtask

   task automatic test_back_to_back_dumps();
      send_item(command_item(odo_pkg::CmdDump));
      send_item(command_item(odo_pkg::CmdDump));
      send_item(motion_item(1'b0, 1'b1, 12'h0A5, 12'hF5A));
      send_item(command_item(odo_pkg::CmdDump));
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      int               pick;
      odo_pkg::req_type r;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            r = motion_item(1'($urandom), 1'b1, 12'($urandom), 12'($urandom));
            if ($urandom_range(9) == 0) begin
               r = motion_item(r.port, 1'b1, ($urandom_range(1) != 0) ? 12'h7FF : 12'h800,
                               ($urandom_range(1) != 0) ? 12'h7FF : 12'h800);
            end
         end else if (pick < 82) begin
            r = command_item(odo_pkg::CmdDump);
         end else if (pick < 90) begin
            r = motion_item(1'($urandom), 1'b0, 12'($urandom), 12'($urandom));
         end else begin
            r = odo_pkg::req_type'($urandom);
            r.op = odo_pkg::OpCommand;
         end
         send_item(r);
      end
   endtask

   initial begin
      clear_sums();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_dump();
      test_delta_extremes();
      test_wrap();
      test_ignored_items();
      test_back_to_back_dumps();
      test_random_traffic(0, 0, 62);
      test_random_traffic(64, 0, 62);
      test_random_traffic(0, 64, 62);
      test_random_traffic(33, 33, 62);
      send_item(command_item(odo_pkg::CmdDump));

      release_inputs();
      wait_drained();

      $display("Covered %0d items (motion, ignored and command) and %0d dump frames,",
               sent_count, frame_count);
      $display("with %0d frame bytes checked across four idle and stall mixes.", byte_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
